/* sv/vca_pkg.sv */
package vca_pkg;

  localparam int KEY_W  = 5;
  localparam int SRC_W  = 2;
  localparam int CH_W   = 3;
  localparam int NOTE_W = 7;
  localparam int OP_W   = 2;
  localparam int KIND_W = 3;

  localparam int FM_VOICES_DEF    = 6;
  localparam int SSG_VOICES_DEF   = 3;
  localparam int ADPCM_VOICES_DEF = 1;
  localparam int TABLE_DEPTH_DEF  = 16;

  localparam logic [KEY_W-1:0] MIDI_KEY = KEY_W'(30);

  typedef enum logic [OP_W-1:0] {
    OP_KEY_ON  = 2'd0,
    OP_KEY_OFF = 2'd1,
    OP_REINIT  = 2'd2
  } op_t;

  typedef enum logic [SRC_W-1:0] {
    SRC_FM    = 2'd0,
    SRC_SSG   = 2'd1,
    SRC_ADPCM = 2'd2
  } src_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_GRANTED   = 3'd0,
    KIND_DISPLACED = 3'd1,
    KIND_RELEASED  = 3'd2,
    KIND_ALREADY   = 3'd3,
    KIND_NO_VOICE  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SRC_W-1:0]  src;
    logic [CH_W-1:0]   ch;
    logic [NOTE_W-1:0] note;
  } entry_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [KEY_W-1:0]  key_code;
    logic [SRC_W-1:0]  source;
    logic [CH_W-1:0]   req_channel;
    logic [NOTE_W-1:0] midi_note;
  } in_beat_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  out_key;
    logic [SRC_W-1:0]  out_source;
    logic [CH_W-1:0]   out_channel;
    logic [NOTE_W-1:0] out_note;
    logic              last;
  } out_beat_t;

  typedef struct packed {
    logic adv;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    logic            pop;
    logic            push;
    logic            reinit;
    logic            poly;
    logic [CH_W-1:0] ch;
  } dq_ctl_t;

endpackage

/* sv/vca_chan_if.sv */
interface vca_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/vca_cell.sv */
module vca_cell import vca_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    nbr,
  input  entry_t    bcast,
  output entry_t    q
);

  entry_t q_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q_r <= bcast;
    end else if (ctl.adv) begin
      q_r <= nbr;
    end
  end

  assign q = q_r;

endmodule

/* sv/vca_deque.sv */
module vca_deque import vca_pkg::*; #(
  parameter int DEPTH = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dq_ctl_t         ctl,
  output logic            avail,
  output logic [CH_W-1:0] front
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CH_W-1:0]  slot_r [DEPTH];
  logic [CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_W'(DEPTH);
      for (int j = 0; j < DEPTH; j++) slot_r[j] <= CH_W'(j);
    end else if (ctl.reinit) begin
      if (ctl.poly) begin
        cnt_r <= CNT_W'(DEPTH);
        for (int j = 0; j < DEPTH; j++) slot_r[j] <= CH_W'(j);
      end else begin
        if (cnt_r == '0) slot_r[0] <= '0;
        cnt_r <= CNT_W'(1);
      end
    end else if (ctl.pop && cnt_r != '0) begin
      for (int j = 0; j < DEPTH - 1; j++) slot_r[j] <= slot_r[j+1];
      cnt_r <= cnt_r - CNT_W'(1);
    end else if (ctl.push && cnt_r < CNT_W'(DEPTH)) begin
      for (int j = 1; j < DEPTH; j++) slot_r[j] <= slot_r[j-1];
      slot_r[0] <= ctl.ch;
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  assign avail = (cnt_r != '0);
  assign front = slot_r[0];

endmodule

/* sv/voice_channel_allocator.sv */
// Voice channel allocator. Held keys live oldest first in a row of cells
// that rotates one entry per cycle past a single compare point at its head;
// the first matching entry is dropped from the row as it passes, and a new
// entry is written at the tail afterwards. One item is in work at a time:
// a key on or key off rotates every held entry past the head, then passes
// an end-of-scan step and a decide step before its first result beat. Each
// beat then waits for the sink, and the input is ready again the cycle after
// the last beat is taken. Reinitialize gives no beat.
// Free voices sit in one small shift deque per source.
// There is no clearing pass after reset.
module voice_channel_allocator import vca_pkg::*; #(
  parameter int FM_VOICES    = FM_VOICES_DEF,
  parameter int SSG_VOICES   = SSG_VOICES_DEF,
  parameter int ADPCM_VOICES = ADPCM_VOICES_DEF,
  parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  vca_chan_if.sink   in_chan,
  vca_chan_if.source out_chan,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DONE = 4'b0100,
    ST_SEND = 4'b1000
  } state_t;

  state_t            state_r;
  logic              poly_r;
  logic [CNT_W-1:0]  n_r;
  logic [CNT_W-1:0]  left_r;
  logic              found_r;
  logic              free_avail_r;
  logic              pend_r;
  entry_t            del_r;
  logic [OP_W-1:0]   op_r;
  logic [KEY_W-1:0]  key_r;
  logic [SRC_W-1:0]  src_r;
  logic [CH_W-1:0]   rch_r;
  logic [NOTE_W-1:0] note_r;
  out_beat_t         res_r;
  out_beat_t         res2_r;

  entry_t    cell_q   [TABLE_DEPTH];
  cell_ctl_t cell_ctl [TABLE_DEPTH];
  entry_t    head;
  entry_t    bcast;
  entry_t    new_e;

  dq_ctl_t         dq_ctl [3];
  logic            dq_avail [3];
  logic [CH_W-1:0] dq_front [3];
  logic [CH_W-1:0] front_sel;
  logic            in_avail;

  in_beat_t  ib;
  logic      in_acc;
  logic      scan_step;
  logic      crit;
  logic      match;
  logic      done;
  logic      append_en;
  logic      pop_en;
  logic      push_en;
  logic      two;
  out_beat_t r1;
  out_beat_t r2;

  assign ib             = in_chan.data;
  assign in_chan.ready  = (state_r == ST_IDLE);
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign out_chan.valid = (state_r == ST_SEND);
  assign out_chan.data  = res_r;

  // held-key cell row
  assign head = cell_q[0];

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t nbr;
    if (i == TABLE_DEPTH - 1) begin : g_end
      assign nbr = bcast;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end
    vca_cell u_cell (
      .clk   (clk),
      .ctl   (cell_ctl[i]),
      .nbr   (nbr),
      .bcast (bcast),
      .q     (cell_q[i])
    );
  end

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      cell_ctl[i].adv  = scan_step;
      cell_ctl[i].load = (scan_step && !match && n_r == CNT_W'(i + 1)) ||
                         (append_en && n_r == CNT_W'(i));
    end
  end

  assign bcast = append_en ? new_e : head;

  // free voice deques
  vca_deque #(.DEPTH(FM_VOICES)) u_dq_fm (
    .clk (clk), .rst_n (rst_n), .ctl (dq_ctl[0]),
    .avail (dq_avail[0]), .front (dq_front[0])
  );
  vca_deque #(.DEPTH(SSG_VOICES)) u_dq_ssg (
    .clk (clk), .rst_n (rst_n), .ctl (dq_ctl[1]),
    .avail (dq_avail[1]), .front (dq_front[1])
  );
  vca_deque #(.DEPTH(ADPCM_VOICES)) u_dq_adpcm (
    .clk (clk), .rst_n (rst_n), .ctl (dq_ctl[2]),
    .avail (dq_avail[2]), .front (dq_front[2])
  );

  always_comb begin
    for (int s = 0; s < 3; s++) begin
      dq_ctl[s].pop    = pop_en && (src_r == SRC_W'(s));
      dq_ctl[s].push   = push_en && (del_r.src == SRC_W'(s));
      dq_ctl[s].reinit = in_acc && (ib.opcode == OP_REINIT);
      dq_ctl[s].poly   = poly_r;
      dq_ctl[s].ch     = del_r.ch;
    end
  end

  always_comb begin
    case (src_r)
      SRC_FM:    front_sel = dq_front[0];
      SRC_SSG:   front_sel = dq_front[1];
      SRC_ADPCM: front_sel = dq_front[2];
      default:   front_sel = '0;
    endcase
    case (ib.source)
      SRC_FM:    in_avail = dq_avail[0];
      SRC_SSG:   in_avail = dq_avail[1];
      SRC_ADPCM: in_avail = dq_avail[2];
      default:   in_avail = 1'b0;
    endcase
  end

  // scan compare at the head cell
  always_comb begin
    if (op_r == OP_KEY_OFF) begin
      crit = (key_r == MIDI_KEY) ? (head.key == MIDI_KEY && head.note == note_r)
                                 : (head.key == key_r);
    end else if (free_avail_r) begin
      crit = (key_r != MIDI_KEY) && (head.src == src_r) && (head.key == key_r);
    end else begin
      crit = (head.src == src_r);
    end
  end

  assign scan_step = (state_r == ST_SCAN) && (left_r != '0);
  assign match     = scan_step && !found_r && crit;
  assign done      = (state_r == ST_DONE);

  // decide step
  always_comb begin
    new_e.key  = key_r;
    new_e.src  = src_r;
    new_e.note = note_r;
    if (!poly_r)      new_e.ch = rch_r;
    else if (found_r) new_e.ch = del_r.ch;
    else              new_e.ch = front_sel;

    append_en = 1'b0;
    pop_en    = 1'b0;
    push_en   = 1'b0;
    two       = 1'b0;
    r1 = '{kind: KIND_ALREADY, out_key: key_r, out_source: '0, out_channel: '0,
           out_note: '0, last: 1'b1};
    r2 = '{kind: KIND_DISPLACED, out_key: del_r.key, out_source: del_r.src,
           out_channel: del_r.ch, out_note: del_r.note, last: 1'b1};

    if (op_r == OP_KEY_OFF) begin
      if (found_r) begin
        push_en = done;
        r1.kind        = KIND_RELEASED;
        r1.out_source  = del_r.src;
        r1.out_channel = del_r.ch;
      end
    end else if (found_r) begin
      append_en = done;
      two       = 1'b1;
      r1 = '{kind: KIND_GRANTED, out_key: new_e.key, out_source: new_e.src,
             out_channel: new_e.ch, out_note: new_e.note, last: 1'b0};
    end else if (!free_avail_r || n_r == CNT_W'(TABLE_DEPTH)) begin
      r1.kind       = KIND_NO_VOICE;
      r1.out_source = src_r;
    end else begin
      append_en = done;
      pop_en    = done;
      r1 = '{kind: KIND_GRANTED, out_key: new_e.key, out_source: new_e.src,
             out_channel: new_e.ch, out_note: new_e.note, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      poly_r  <= 1'b1;
      n_r     <= '0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (cfg_we) poly_r <= cfg_wdata;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            op_r         <= ib.opcode;
            key_r        <= ib.key_code;
            src_r        <= ib.source;
            rch_r        <= ib.req_channel;
            note_r       <= ib.midi_note;
            left_r       <= n_r;
            found_r      <= 1'b0;
            free_avail_r <= in_avail;
            if (ib.opcode == OP_KEY_OFF ||
                (ib.opcode == OP_KEY_ON &&
                 ib.source inside {SRC_FM, SRC_SSG, SRC_ADPCM})) begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (left_r == '0) begin
            state_r <= ST_DONE;
          end else begin
            left_r <= left_r - CNT_W'(1);
            if (match) begin
              found_r <= 1'b1;
              del_r   <= head;
              n_r     <= n_r - CNT_W'(1);
            end
          end
        end
        ST_DONE: begin
          if (append_en) n_r <= n_r + CNT_W'(1);
          res_r   <= r1;
          res2_r  <= r2;
          pend_r  <= two;
          state_r <= ST_SEND;
        end
        ST_SEND: begin
          if (out_chan.ready) begin
            if (pend_r) begin
              res_r  <= res2_r;
              pend_r <= 1'b0;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import vca_pkg::*;

  localparam logic [OP_W-1:0]  OP_INVALID  = 2'd3;
  localparam logic [SRC_W-1:0] SRC_INVALID = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_EVENTS  = 150;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic cfg_wdata;

  vca_chan_if #(.T(in_beat_t))  in_if ();
  vca_chan_if #(.T(out_beat_t)) out_if ();

  voice_channel_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // allocator mirror
  logic            poly_mode;
  entry_t          held_q[$];
  logic [CH_W-1:0] free_ch [3][8];
  int              free_n [3];
  int              voice_cap [3] = '{FM_VOICES_DEF, SSG_VOICES_DEF, ADPCM_VOICES_DEF};

  in_beat_t  key_events[$];
  out_beat_t expected_voice_beats[$];
  int        fail_count = 0;

  logic        in_taken = 1'b0;
  int          gap_left = 0;
  int          burst_left = 1;
  logic [15:0] stall_mask = '1;
  logic [5:0]  sink_phase = '0;

  function automatic void push_expected(kind_t kind, logic [KEY_W-1:0] key,
                                        logic [SRC_W-1:0] src, logic [CH_W-1:0] ch,
                                        logic [NOTE_W-1:0] note, logic last);
    out_beat_t b;
    b.kind        = kind;
    b.out_key     = key;
    b.out_source  = src;
    b.out_channel = ch;
    b.out_note    = note;
    b.last        = last;
    expected_voice_beats = {expected_voice_beats, b};
  endfunction

  function automatic void predict_allocation(in_beat_t b);
    entry_t fresh;
    entry_t gone;
    int     hit;
    int     s;
    hit = -1;
    s   = b.source;
    if (b.opcode == OP_REINIT) begin
      for (int q = 0; q < 3; q++) begin
        if (poly_mode) begin
          for (int j = 0; j < voice_cap[q]; j++) free_ch[q][j] = CH_W'(j);
          free_n[q] = voice_cap[q];
        end else begin
          if (free_n[q] == 0) free_ch[q][0] = '0;
          free_n[q] = 1;
        end
      end
      return;
    end
    if (b.opcode == OP_KEY_OFF) begin
      for (int i = 0; i < held_q.size() && hit < 0; i++) begin
        if (b.key_code == MIDI_KEY ?
            (held_q[i].key == MIDI_KEY && held_q[i].note == b.midi_note) :
            (held_q[i].key == b.key_code))
          hit = i;
      end
      if (hit < 0) begin
        push_expected(KIND_ALREADY, b.key_code, '0, '0, '0, 1'b1);
        return;
      end
      gone = held_q[hit];
      if (free_n[gone.src] < voice_cap[gone.src]) begin
        for (int j = free_n[gone.src]; j > 0; j--)
          free_ch[gone.src][j] = free_ch[gone.src][j-1];
        free_ch[gone.src][0] = gone.ch;
        free_n[gone.src]++;
      end
      held_q.delete(hit);
      push_expected(KIND_RELEASED, b.key_code, gone.src, gone.ch, '0, 1'b1);
      return;
    end
    if (b.opcode != OP_KEY_ON || b.source == SRC_INVALID) return;

    fresh.key  = b.key_code;
    fresh.src  = b.source;
    fresh.ch   = b.req_channel;
    fresh.note = b.midi_note;
    if (free_n[s] > 0) begin
      if (b.key_code != MIDI_KEY) begin
        for (int i = 0; i < held_q.size() && hit < 0; i++)
          if (held_q[i].src == b.source && held_q[i].key == b.key_code) hit = i;
      end
      if (hit < 0) begin
        if (held_q.size() >= TABLE_DEPTH_DEF) begin
          push_expected(KIND_NO_VOICE, b.key_code, b.source, '0, '0, 1'b1);
          return;
        end
        if (poly_mode) fresh.ch = free_ch[s][0];
        for (int j = 0; j + 1 < free_n[s]; j++) free_ch[s][j] = free_ch[s][j+1];
        free_n[s]--;
        held_q = {held_q, fresh};
        push_expected(KIND_GRANTED, fresh.key, fresh.src, fresh.ch, fresh.note, 1'b1);
        return;
      end
    end else begin
      for (int i = 0; i < held_q.size() && hit < 0; i++)
        if (held_q[i].src == b.source) hit = i;
      if (hit < 0) begin
        push_expected(KIND_NO_VOICE, b.key_code, b.source, '0, '0, 1'b1);
        return;
      end
    end
    // steal or same-key reuse
    gone = held_q[hit];
    if (poly_mode) fresh.ch = gone.ch;
    held_q.delete(hit);
    held_q = {held_q, fresh};
    push_expected(KIND_GRANTED, fresh.key, fresh.src, fresh.ch, fresh.note, 1'b0);
    push_expected(KIND_DISPLACED, gone.key, gone.src, gone.ch, gone.note, 1'b1);
  endfunction

  function automatic void check_voice_beat(out_beat_t got);
    out_beat_t want;
    if (expected_voice_beats.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected beat: kind %0d key %0d src %0d ch %0d note %0d last %0d",
                 got.kind, got.out_key, got.out_source, got.out_channel, got.out_note,
                 got.last);
      return;
    end
    want = expected_voice_beats[0];
    expected_voice_beats.delete(0);
    if (got.kind !== want.kind || got.out_key !== want.out_key ||
        got.out_source !== want.out_source || got.out_channel !== want.out_channel ||
        got.out_note !== want.out_note || got.last !== want.last) begin
      fail_count++;
      if (fail_count <= 10)
        $display("beat mismatch (exp/got): kind %0d/%0d key %0d/%0d src %0d/%0d %s%0d/%0d %s%0d/%0d %s%0d/%0d",
                 want.kind, got.kind, want.out_key, got.out_key,
                 want.out_source, got.out_source, "ch ", want.out_channel, got.out_channel,
                 "note ", want.out_note, got.out_note, "last ", want.last, got.last);
    end
  endfunction

  function automatic void queue_event(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                      logic [SRC_W-1:0] src, logic [CH_W-1:0] ch,
                                      logic [NOTE_W-1:0] note);
    in_beat_t b;
    b.opcode      = op;
    b.key_code    = key;
    b.source      = src;
    b.req_channel = ch;
    b.midi_note   = note;
    key_events = {key_events, b};
  endfunction

  function automatic in_beat_t random_event(int on_pct, int off_pct);
    in_beat_t b;
    int       roll;
    roll = $urandom_range(0, 99);
    b.req_channel = CH_W'($urandom_range(0, 7));
    b.midi_note   = ($urandom_range(0, 3) == 0) ? NOTE_W'($urandom_range(0, 127)) :
                                                  NOTE_W'(60 + $urandom_range(0, 7));
    if ($urandom_range(0, 3) == 0) b.key_code = MIDI_KEY;
    else if ($urandom_range(0, 1) == 0) b.key_code = KEY_W'($urandom_range(0, 7));
    else b.key_code = KEY_W'($urandom_range(0, 31));
    b.source = SRC_W'($urandom_range(0, 2));
    if (roll < on_pct) begin
      b.opcode = OP_KEY_ON;
    end else if (roll < on_pct + off_pct) begin
      b.opcode = OP_KEY_OFF;
    end else if (roll < 97) begin
      b.opcode = OP_REINIT;
    end else if (roll == 97) begin
      b.opcode = OP_INVALID;
    end else begin
      b.opcode = OP_KEY_ON;
      b.source = SRC_INVALID;
    end
    return b;
  endfunction

  task automatic write_poly_mode(input logic mode);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we    <= 1'b0;
    poly_mode = mode;
  endtask

  task automatic drain_allocator();
    while (key_events.size() != 0 || in_if.valid || expected_voice_beats.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("voice_channel_allocator test failed");
    $finish;
  end

  always @(posedge clk) begin
    in_taken <= in_if.valid && in_if.ready;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) predict_allocation(in_if.data);
      if (out_if.valid && out_if.ready) check_voice_beat(out_if.data);
    end else begin
      held_q.delete();
      predict_allocation('{opcode: OP_REINIT, default: '0});
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else if (!in_if.valid || in_taken) begin
      if (gap_left > 0) begin
        in_if.valid <= 1'b0;
        gap_left    <= gap_left - 1;
      end else if (key_events.size() > 0) begin
        in_if.data  <= key_events[0];
        key_events.delete(0);
        in_if.valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          case ($urandom_range(0, 2))
            0:       gap_left <= 0;
            1:       gap_left <= $urandom_range(1, 4);
            default: gap_left <= $urandom_range(5, 25);
          endcase
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (sink_phase == '0) begin
      case ($urandom_range(0, 3))
        0:       stall_mask <= '1;
        1:       stall_mask <= 16'($urandom) | 16'h1;
        2:       stall_mask <= 16'($urandom | $urandom) | 16'h1;
        default: stall_mask <= 16'h1 << $urandom_range(0, 15);
      endcase
    end
    out_if.ready <= rst_n && stall_mask[sink_phase[3:0]];
    sink_phase   <= sink_phase + 1'b1;
  end

  initial begin
    in_beat_t b;
    int       n;
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b0;
    poly_mode    = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_event(OP_KEY_ON,  5'd0,     SRC_FM,      3'd0, 7'd0);
    queue_event(OP_KEY_ON,  5'd29,    SRC_FM,      3'd7, 7'd127);
    queue_event(OP_KEY_ON,  5'd31,    SRC_SSG,     3'd3, 7'd85);
    queue_event(OP_KEY_ON,  MIDI_KEY, SRC_ADPCM,   3'd0, 7'd60);
    queue_event(OP_KEY_ON,  MIDI_KEY, SRC_ADPCM,   3'd0, 7'd61);
    queue_event(OP_KEY_ON,  5'd0,     SRC_FM,      3'd2, 7'd5);
    queue_event(OP_KEY_ON,  5'd1,     SRC_INVALID, 3'd0, 7'd0);
    queue_event(OP_INVALID, 5'd1,     SRC_FM,      3'd0, 7'd0);
    queue_event(OP_KEY_OFF, MIDI_KEY, SRC_FM,      3'd0, 7'd60);
    queue_event(OP_KEY_OFF, MIDI_KEY, SRC_FM,      3'd0, 7'd61);
    queue_event(OP_KEY_OFF, 5'd31,    SRC_FM,      3'd0, 7'd0);
    queue_event(OP_KEY_OFF, 5'd12,    SRC_FM,      3'd0, 7'd0);
    queue_event(OP_REINIT,  5'd0,     SRC_FM,      3'd0, 7'd0);
    drain_allocator();
    write_poly_mode(1'b0);
    queue_event(OP_KEY_ON,  5'd3,     SRC_FM,      3'd5, 7'd42);
    queue_event(OP_KEY_ON,  5'd3,     SRC_FM,      3'd2, 7'd43);
    queue_event(OP_REINIT,  5'd0,     SRC_FM,      3'd0, 7'd0);
    queue_event(OP_KEY_ON,  5'd7,     SRC_SSG,     3'd6, 7'd1);
    queue_event(OP_KEY_ON,  5'd8,     SRC_SSG,     3'd1, 7'd2);
    queue_event(OP_KEY_OFF, 5'd29,    SRC_FM,      3'd0, 7'd0);
    queue_event(OP_KEY_OFF, 5'd0,     SRC_FM,      3'd0, 7'd0);
    queue_event(OP_KEY_OFF, 5'd3,     SRC_FM,      3'd0, 7'd0);
    queue_event(OP_KEY_OFF, 5'd8,     SRC_FM,      3'd0, 7'd0);
    drain_allocator();

    // fill-heavy phases push the held table to full, the others drain it
    for (int ph = 0; ph < 6; ph++) begin
      write_poly_mode((ph == 1 || ph == 3 || ph == 4) ? 1'b1 : 1'b0);
      n = 0;
      while (n < PHASE_EVENTS) begin
        b = (ph % 2 == 0) ? random_event(70, 15) : random_event(35, 55);
        key_events = {key_events, b};
        if (!(b.opcode == OP_INVALID || (b.opcode == OP_KEY_ON && b.source == SRC_INVALID)))
          n++;
      end
      drain_allocator();
    end

    if (fail_count == 0) begin
      $display("voice_channel_allocator test passed");
    end else begin
      $display("voice_channel_allocator test failed");
    end
    $finish;
  end

endmodule
